// ----- sv/frvac_pkg.sv -----
// Shared widths, defaults and op codes for the frame ring vertex allocator.
// No dependencies; imported by frvac_div and frame_ring_vertex_allocator_core.
`default_nettype none

package frvac_pkg;

  localparam int unsigned POS_W          = 32;  // byte position datapath
  localparam int unsigned DVS_W          = 9;   // divisor / stride width
  localparam int unsigned CNT_W          = $clog2(POS_W);
  localparam int unsigned BSIZE_W        = 26;
  localparam int unsigned VOFF_W         = 26;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned SLOT_W         = 3;
  localparam int unsigned FRM_W          = 4;
  localparam int unsigned VCNT_W         = 20;
  localparam int unsigned NEED_W         = VCNT_W + DVS_W;
  localparam int unsigned KIB_BYTES      = 1024;
  localparam int unsigned BUFFER_KIB_DEF = 32768;
  localparam int unsigned MAX_FRAMES_DEF = 8;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME  = 2'd0,
    OP_LOCK   = 2'd1,
    OP_UNLOCK = 2'd2
  } op_e;

endpackage

`default_nettype wire

// ----- sv/frvac_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on frvac_pkg; used by frame_ring_vertex_allocator_core.
`default_nettype none

module frvac_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [frvac_pkg::POS_W-1:0]  dividend_i,
  input  wire logic [frvac_pkg::DVS_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [frvac_pkg::POS_W-1:0]       quotient_o
);
  import frvac_pkg::*;

  logic             active_q, active_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_q[DVS_W-1:0], quo_q[POS_W-1]};
    ge       = (rem_sh >= {1'b0, dvs_q});
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = CNT_W'(POS_W - 1);
      quo_d    = dividend_i;
      rem_d    = '0;
      dvs_d    = divisor_i;
    end else if (active_q) begin
      quo_d = {quo_q[POS_W-2:0], ge};
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rem_q < {1'b0, dvs_q}))
    else $error("divider remainder not below divisor");

  a_dvs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (divisor_i != '0))
    else $error("divider started with zero divisor");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !active_q)
    else $error("divider restarted while active");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !active_q)
    else $error("divider done while still active");

endmodule

`default_nettype wire

// ----- sv/frame_ring_vertex_allocator_core.sv -----
// Top level of the frame ring vertex allocator: sequencer, shared multiplier.
// Depends on frvac_pkg and frvac_div.
//
// Usage: drive op_i and the item fields with start high; the beat is taken
// at a clock edge where start is high and busy is low. Exactly one result
// beat follows per item, shown for one cycle with done_o high; the receiver
// cannot hold it off. The next item may be started during that cycle.
// Path from accept to done_o, via the serial divider (one quotient bit per
// cycle) and the sequencer: frame reset with nonzero frame count: S_DIV,
// S_FINISH, else direct; lock: S_MUL, S_CHECK, S_DIV, S_QMUL, S_FIT,
// S_COMMIT, S_PEAK, with S_DIV and S_QMUL again on a wrap; refused lock and
// unlock: S_MUL, S_CHECK; unused op: direct. One item is in work at a time.
// The user must have buffer_size written with cfg_we_i only while the block
// is idle; the block does not enforce this. It only affects later frame
// resets. Reset returns buffer_size and the region size to BUFFER_KIB * 1024
// bytes and clears position, base and all statistics.
`default_nettype none

module frame_ring_vertex_allocator_core #(
  parameter int unsigned BUFFER_KIB           = frvac_pkg::BUFFER_KIB_DEF,
  parameter int unsigned MAX_FRAMES_IN_FLIGHT = frvac_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           cfg_we_i,
  input  wire logic [frvac_pkg::BSIZE_W-1:0]  cfg_wdata_i,
  input  wire logic [frvac_pkg::OP_W-1:0]     op_i,
  input  wire logic [frvac_pkg::SLOT_W-1:0]   frame_slot_i,
  input  wire logic [frvac_pkg::FRM_W-1:0]    frames_in_flight_i,
  input  wire logic [frvac_pkg::VCNT_W-1:0]   vertex_count_i,
  input  wire logic [frvac_pkg::DVS_W-1:0]    stride_i,
  output logic                                done_o,
  output logic                                status_o,
  output logic [frvac_pkg::POS_W-1:0]         byte_offset_o,
  output logic [frvac_pkg::VOFF_W-1:0]        vertex_offset_o,
  output logic                                wrapped_o,
  output logic [frvac_pkg::POS_W-1:0]         discard_count_o,
  output logic [frvac_pkg::POS_W-1:0]         peak_bytes_o,
  output logic [frvac_pkg::POS_W-1:0]         frame_wraps_o,
  output logic [frvac_pkg::POS_W-1:0]         frame_calls_o
);
  import frvac_pkg::*;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(BUFFER_KIB * KIB_BYTES);
  localparam logic [FRM_W:0]     MAX_F     = (FRM_W + 1)'(MAX_FRAMES_IN_FLIGHT);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_CHECK  = 9'b000000100,
    S_DIV    = 9'b000001000,
    S_QMUL   = 9'b000010000,
    S_FIT    = 9'b000100000,
    S_COMMIT = 9'b001000000,
    S_PEAK   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // architectural state
  logic [BSIZE_W-1:0] bsize_q, bsize_d;
  logic [POS_W-1:0]   position_q, position_d;
  logic [POS_W-1:0]   base_q, base_d;
  logic [BSIZE_W-1:0] region_q, region_d;
  logic [POS_W-1:0]   discard_q, discard_d;
  logic [POS_W-1:0]   peak_q, peak_d;
  logic [POS_W-1:0]   fwrap_q, fwrap_d;
  logic [POS_W-1:0]   fcall_q, fcall_d;

  // item and working registers
  logic [OP_W-1:0]    op_q, op_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [VCNT_W-1:0]  count_q, count_d;
  logic [DVS_W-1:0]   stride_q, stride_d;
  logic [NEED_W-1:0]  need_q, need_d;
  logic [POS_W-1:0]   end_q, end_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   use_q, use_d;
  logic               wrap_q, wrap_d;

  // result registers
  logic               res_status_q, res_status_d;
  logic [POS_W-1:0]   res_boff_q, res_boff_d;
  logic [VOFF_W-1:0]  res_voff_q, res_voff_d;
  logic               res_wrapped_q, res_wrapped_d;
  logic [POS_W-1:0]   res_peak_q, res_peak_d;
  logic [POS_W-1:0]   res_fwrap_q, res_fwrap_d;
  logic [POS_W-1:0]   res_fcall_q, res_fcall_d;

  logic [FRM_W:0]         frames_c;
  logic [POS_W-1:0]       mul_a;
  logic [DVS_W-1:0]       mul_b;
  logic [POS_W+DVS_W-1:0] mul_p;
  logic                   div_start;
  logic [POS_W-1:0]       div_dvd;
  logic [DVS_W-1:0]       div_dvs;
  logic                   div_done;
  logic [POS_W-1:0]       div_quo;
  logic [POS_W-1:0]       fit_sum;
  logic [POS_W-1:0]       fcall_inc;
  logic [POS_W-1:0]       fwrap_new;

  frvac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign frames_c = ({1'b0, frames_in_flight_i} > MAX_F) ? MAX_F
                                                         : {1'b0, frames_in_flight_i};
  assign busy     = (state_q != S_IDLE);

  // shared multiplier, result always lands in a register
  always_comb begin
    case (state_q)
      S_MUL: begin
        mul_a = POS_W'(count_q);
        mul_b = stride_q;
      end
      S_FINISH: begin
        mul_a = POS_W'(region_q);
        mul_b = DVS_W'(slot_q);
      end
      default: begin
        mul_a = div_quo;
        mul_b = stride_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign fit_sum   = pos_q + POS_W'(need_q);
  assign fcall_inc = fcall_q + POS_W'(1);
  assign fwrap_new = wrap_q ? (fwrap_q + POS_W'(1)) : fwrap_q;

  always_comb begin
    state_d       = state_q;
    done_d        = 1'b0;
    bsize_d       = cfg_we_i ? cfg_wdata_i : bsize_q;
    position_d    = position_q;
    base_d        = base_q;
    region_d      = region_q;
    discard_d     = discard_q;
    peak_d        = peak_q;
    fwrap_d       = fwrap_q;
    fcall_d       = fcall_q;
    op_d          = op_q;
    slot_d        = slot_q;
    count_d       = count_q;
    stride_d      = stride_q;
    need_d        = need_q;
    end_d         = end_q;
    pos_d         = pos_q;
    use_d         = use_q;
    wrap_d        = wrap_q;
    res_status_d  = res_status_q;
    res_boff_d    = res_boff_q;
    res_voff_d    = res_voff_q;
    res_wrapped_d = res_wrapped_q;
    res_peak_d    = res_peak_q;
    res_fwrap_d   = res_fwrap_q;
    res_fcall_d   = res_fcall_q;
    div_start     = 1'b0;
    div_dvd       = position_q + POS_W'(stride_q) - POS_W'(1);
    div_dvs       = stride_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d          = op_i;
          slot_d        = frame_slot_i;
          count_d       = vertex_count_i;
          stride_d      = stride_i;
          res_status_d  = 1'b0;
          res_boff_d    = '0;
          res_voff_d    = '0;
          res_wrapped_d = 1'b0;
          res_peak_d    = peak_q;
          res_fwrap_d   = fwrap_q;
          res_fcall_d   = fcall_q;
          case (op_i)
            OP_FRAME: begin
              peak_d  = '0;
              fwrap_d = '0;
              fcall_d = '0;
              if (frames_c != '0) begin
                div_start = 1'b1;
                div_dvd   = POS_W'(bsize_q);
                div_dvs   = DVS_W'(frames_c);
                state_d   = S_DIV;
              end else begin
                done_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
            OP_LOCK, OP_UNLOCK: begin
              state_d = S_MUL;
            end
            default: begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        need_d  = mul_p[NEED_W-1:0];
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (op_q == OP_UNLOCK) begin
          position_d = position_q + POS_W'(need_q);
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else if (count_q == '0 || stride_q == '0 ||
                     POS_W'(need_q) > POS_W'(region_q)) begin
          res_status_d = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          end_d     = base_q + POS_W'(region_q);
          wrap_d    = 1'b0;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_q == OP_FRAME) begin
            region_d = div_quo[BSIZE_W-1:0];
            state_d  = S_FINISH;
          end else begin
            state_d = S_QMUL;
          end
        end
      end
      S_QMUL: begin
        pos_d   = mul_p[POS_W-1:0];
        state_d = wrap_q ? S_COMMIT : S_FIT;
      end
      S_FIT: begin
        if (fit_sum > end_q) begin
          wrap_d    = 1'b1;
          div_start = 1'b1;
          div_dvd   = base_q + POS_W'(stride_q) - POS_W'(1);
          state_d   = S_DIV;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        use_d   = fit_sum - base_q;
        state_d = S_PEAK;
      end
      S_PEAK: begin
        fcall_d       = fcall_inc;
        fwrap_d       = fwrap_new;
        discard_d     = wrap_q ? (discard_q + POS_W'(1)) : discard_q;
        peak_d        = (use_q > peak_q) ? use_q : peak_q;
        position_d    = pos_q;
        res_boff_d    = pos_q;
        res_voff_d    = div_quo[VOFF_W-1:0];
        res_wrapped_d = wrap_q;
        res_peak_d    = (use_q > peak_q) ? use_q : peak_q;
        res_fwrap_d   = fwrap_new;
        res_fcall_d   = fcall_inc;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end
      S_FINISH: begin
        // frame reset: base = slot * region size
        base_d     = mul_p[POS_W-1:0];
        position_d = mul_p[POS_W-1:0];
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      bsize_q    <= BSIZE_RST;
      position_q <= '0;
      base_q     <= '0;
      region_q   <= BSIZE_RST;
      discard_q  <= '0;
      peak_q     <= '0;
      fwrap_q    <= '0;
      fcall_q    <= '0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      bsize_q    <= bsize_d;
      position_q <= position_d;
      base_q     <= base_d;
      region_q   <= region_d;
      discard_q  <= discard_d;
      peak_q     <= peak_d;
      fwrap_q    <= fwrap_d;
      fcall_q    <= fcall_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    slot_q        <= slot_d;
    count_q       <= count_d;
    stride_q      <= stride_d;
    need_q        <= need_d;
    end_q         <= end_d;
    pos_q         <= pos_d;
    use_q         <= use_d;
    wrap_q        <= wrap_d;
    res_status_q  <= res_status_d;
    res_boff_q    <= res_boff_d;
    res_voff_q    <= res_voff_d;
    res_wrapped_q <= res_wrapped_d;
    res_peak_q    <= res_peak_d;
    res_fwrap_q   <= res_fwrap_d;
    res_fcall_q   <= res_fcall_d;
  end

  assign done_o          = done_q;
  assign status_o        = res_status_q;
  assign byte_offset_o   = res_boff_q;
  assign vertex_offset_o = res_voff_q;
  assign wrapped_o       = res_wrapped_q;
  assign discard_count_o = discard_q;
  assign peak_bytes_o    = res_peak_q;
  assign frame_wraps_o   = res_fwrap_q;
  assign frame_calls_o   = res_fcall_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result beat while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_LOCK || op_i == OP_UNLOCK)) |=> busy)
    else $error("lock or unlock accepted without going busy");

  a_wrap_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_wrapped_q) |-> !res_status_q)
    else $error("refused lock flagged as wrapped");

  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_status_q) |-> (res_boff_q == '0 && res_voff_q == '0))
    else $error("refused lock carries an offset");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for frame_ring_vertex_allocator_core: directed and random
// frame reset, lock and unlock beats, each result compared with an in-bench model.
// Depends on frvac_pkg and the core RTL only.
module testbench;
  import frvac_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED  = 2'd3;
  localparam logic               ST_OK      = 1'b0;
  localparam logic               ST_REFUSED = 1'b1;
  localparam logic [BSIZE_W-1:0] BUF_RESET  = 26'(BUFFER_KIB_DEF * KIB_BYTES);
  localparam logic [BSIZE_W-1:0] BUF_MAX    = '1;
  localparam logic [VCNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [DVS_W-1:0]   STRIDE_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [FRM_W-1:0]  frames;
    logic [VCNT_W-1:0] count;
    logic [DVS_W-1:0]  stride;
  } alloc_req_t;

  typedef struct packed {
    logic              status;
    logic [POS_W-1:0]  byte_offset;
    logic [VOFF_W-1:0] vertex_offset;
    logic              wrapped;
    logic [POS_W-1:0]  discard_count;
    logic [POS_W-1:0]  peak_bytes;
    logic [POS_W-1:0]  frame_wraps;
    logic [POS_W-1:0]  frame_calls;
  } alloc_grant_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cfg_we_i;
  logic [BSIZE_W-1:0]  cfg_wdata_i;
  logic [OP_W-1:0]     op_i;
  logic [SLOT_W-1:0]   frame_slot_i;
  logic [FRM_W-1:0]    frames_in_flight_i;
  logic [VCNT_W-1:0]   vertex_count_i;
  logic [DVS_W-1:0]    stride_i;
  logic                done_o;
  logic                status_o;
  logic [POS_W-1:0]    byte_offset_o;
  logic [VOFF_W-1:0]   vertex_offset_o;
  logic                wrapped_o;
  logic [POS_W-1:0]    discard_count_o;
  logic [POS_W-1:0]    peak_bytes_o;
  logic [POS_W-1:0]    frame_wraps_o;
  logic [POS_W-1:0]    frame_calls_o;

  // allocator model state
  logic [BSIZE_W-1:0]  buf_size;
  logic [BSIZE_W-1:0]  region_size;
  logic [POS_W-1:0]    position;
  logic [POS_W-1:0]    region_base;
  logic [POS_W-1:0]    discard_total;
  logic [POS_W-1:0]    peak_bytes_n;
  logic [POS_W-1:0]    frame_wraps_n;
  logic [POS_W-1:0]    frame_calls_n;

  alloc_grant_t        expected_grants[$];
  alloc_grant_t        last_grant;
  alloc_grant_t        head;
  int                  mismatches = 0;
  bit                  steady = 1'b0;

  frame_ring_vertex_allocator_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .op_i               (op_i),
    .frame_slot_i       (frame_slot_i),
    .frames_in_flight_i (frames_in_flight_i),
    .vertex_count_i     (vertex_count_i),
    .stride_i           (stride_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .byte_offset_o      (byte_offset_o),
    .vertex_offset_o    (vertex_offset_o),
    .wrapped_o          (wrapped_o),
    .discard_count_o    (discard_count_o),
    .peak_bytes_o       (peak_bytes_o),
    .frame_wraps_o      (frame_wraps_o),
    .frame_calls_o      (frame_calls_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [POS_W-1:0] round_up_to(input logic [POS_W-1:0] v,
                                                   input logic [POS_W-1:0] s);
    logic [POS_W-1:0] t;
    t = v + s - 32'd1;
    return (t / s) * s;
  endfunction

  function automatic alloc_grant_t compute_grant(input alloc_req_t r);
    alloc_grant_t     g;
    logic [POS_W-1:0] frm;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] need;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] region_end;
    logic [POS_W-1:0] reach;
    g = '0;
    s = {23'd0, r.stride};
    need = {12'd0, r.count} * s;
    if (r.op == OP_FRAME) begin
      g.peak_bytes = peak_bytes_n;
      g.frame_wraps = frame_wraps_n;
      g.frame_calls = frame_calls_n;
      peak_bytes_n = '0;
      frame_wraps_n = '0;
      frame_calls_n = '0;
      frm = {28'd0, r.frames};
      if (frm > MAX_FRAMES_DEF) frm = MAX_FRAMES_DEF;
      if (frm != 0) begin
        region_size = 26'({6'd0, buf_size} / frm);
        region_base = {29'd0, r.slot} * {6'd0, region_size};
        position = region_base;
      end
    end else begin
      if (r.op == OP_LOCK) begin
        if (r.count == 0 || r.stride == 0 || need > {6'd0, region_size}) begin
          g.status = ST_REFUSED;
        end else begin
          region_end = region_base + {6'd0, region_size};
          pos = round_up_to(position, s);
          frame_calls_n++;
          reach = pos + need;
          if (reach > region_end) begin
            pos = round_up_to(region_base, s);
            discard_total++;
            frame_wraps_n++;
            g.wrapped = 1'b1;
          end
          reach = pos + need - region_base;
          if (reach > peak_bytes_n) peak_bytes_n = reach;
          position = pos;
          g.byte_offset = pos;
          g.vertex_offset = 26'(pos / s);
        end
      end else if (r.op == OP_UNLOCK) begin
        position = position + need;
      end
      g.peak_bytes = peak_bytes_n;
      g.frame_wraps = frame_wraps_n;
      g.frame_calls = frame_calls_n;
    end
    g.discard_count = discard_total;
    return g;
  endfunction

  function automatic alloc_req_t mk_req(input logic [OP_W-1:0] op,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [FRM_W-1:0] frames,
                                        input logic [VCNT_W-1:0] count,
                                        input logic [DVS_W-1:0] stride);
    alloc_req_t r;
    r.op = op;
    r.slot = slot;
    r.frames = frames;
    r.count = count;
    r.stride = stride;
    return r;
  endfunction

  function automatic logic [DVS_W-1:0] rand_stride();
    case ($urandom_range(9))
      0:       return 9'($urandom_range(257, 511));
      1:       return 9'(1 << $urandom_range(0, 8));
      2, 3:    return 9'($urandom_range(1, 4));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  // counts sized against the current region so that locks wrap often
  function automatic logic [VCNT_W-1:0] rand_count(input logic [DVS_W-1:0] s);
    logic [POS_W-1:0] lim;
    lim = (s == 0) ? 32'd0 : {6'd0, region_size} / {23'd0, s} / 32'd3;
    if ($urandom_range(99) < 15) lim = lim * 4;
    if (lim > {12'd0, COUNT_MAX}) lim = {12'd0, COUNT_MAX};
    if (lim == 0) return 20'($urandom_range(1, 4));
    return 20'($urandom_range(1, lim));
  endfunction

  function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                      input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: result beat with no request pending", $time);
        mismatches++;
      end else begin
        head = expected_grants.pop_front();
        check_field("status", 32'(head.status), 32'(status_o));
        check_field("byte_offset", head.byte_offset, byte_offset_o);
        check_field("vertex_offset", 32'(head.vertex_offset), 32'(vertex_offset_o));
        check_field("wrapped", 32'(head.wrapped), 32'(wrapped_o));
        check_field("discard_count", head.discard_count, discard_count_o);
        check_field("peak_bytes", head.peak_bytes, peak_bytes_o);
        check_field("frame_wraps", head.frame_wraps, frame_wraps_o);
        check_field("frame_calls", head.frame_calls, frame_calls_o);
      end
    end
  end

  task automatic send_beat(input alloc_req_t r);
    @(negedge clk_i);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        start <= 1'b0;
        {op_i, frame_slot_i, frames_in_flight_i, vertex_count_i, stride_i} <=
            38'({$urandom, $urandom});
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    op_i <= r.op;
    frame_slot_i <= r.slot;
    frames_in_flight_i <= r.frames;
    vertex_count_i <= r.count;
    stride_i <= r.stride;
    do @(posedge clk_i); while (busy);
    last_grant = compute_grant(r);
    expected_grants.push_back(last_grant);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_buffer_size(input logic [BSIZE_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    buf_size = value;
  endtask

  task automatic test_lock_corners();
    send_beat(mk_req(OP_LOCK, 0, 0, 1, 1));
    send_beat(mk_req(OP_UNLOCK, 0, 0, 1, 1));
    send_beat(mk_req(OP_LOCK, 0, 0, 5, 3));
    send_beat(mk_req(OP_LOCK, 0, 0, 0, 4));
    send_beat(mk_req(OP_LOCK, 0, 0, 7, 0));
    send_beat(mk_req(OP_LOCK, 0, 0, COUNT_MAX, STRIDE_MAX));
    // request exactly the region size, forces a wrap
    send_beat(mk_req(OP_LOCK, 0, 0, 20'd131072, 9'd256));
    send_beat(mk_req(OP_UNUSED, '1, '1, COUNT_MAX, STRIDE_MAX));
  endtask

  task automatic test_frame_resets();
    send_beat(mk_req(OP_FRAME, 5, 0, 0, 0));
    send_beat(mk_req(OP_FRAME, 7, 15, 0, 0));
    send_beat(mk_req(OP_LOCK, 0, 0, 1, STRIDE_MAX));
    send_beat(mk_req(OP_FRAME, 7, 1, 0, 0));
  endtask

  task automatic test_unlock_wraparound();
    repeat (9) send_beat(mk_req(OP_UNLOCK, 0, 0, COUNT_MAX, STRIDE_MAX));
    send_beat(mk_req(OP_LOCK, 0, 0, 3, 9'd256));
    send_beat(mk_req(OP_FRAME, 0, 8, 0, 0));
  endtask

  task automatic test_buffer_extremes();
    write_buffer_size(26'd2);
    send_beat(mk_req(OP_FRAME, 0, 1, 0, 0));
    send_beat(mk_req(OP_LOCK, 0, 0, 2, 1));
    send_beat(mk_req(OP_LOCK, 0, 0, 3, 1));
    send_beat(mk_req(OP_FRAME, 2, 3, 0, 0));
    send_beat(mk_req(OP_LOCK, 0, 0, 1, 1));
    write_buffer_size('0);
    send_beat(mk_req(OP_FRAME, 1, 2, 0, 0));
    send_beat(mk_req(OP_LOCK, 0, 0, 1, 1));
  endtask

  task automatic test_random_traffic();
    logic [BSIZE_W-1:0] sizes [6];
    logic [DVS_W-1:0]   s;
    logic [VCNT_W-1:0]  c;
    logic [VCNT_W-1:0]  cu;
    logic [FRM_W-1:0]   frm;
    int                 pick;
    int                 sent_n;
    sizes[0] = BUF_RESET;
    sizes[1] = 26'd4096;
    sizes[2] = 26'($urandom_range(1, 67108863));
    sizes[3] = BUF_MAX;
    sizes[4] = 26'd2;
    sizes[5] = 26'($urandom_range(64, 20000));
    for (int k = 0; k < 6; k++) begin
      write_buffer_size(sizes[k]);
      steady = (k == 2);
      send_beat(mk_req(OP_FRAME, 3'($urandom_range(7)), 4'($urandom_range(1, 8)),
                       20'($urandom), 9'($urandom)));
      sent_n = 1;
      while (sent_n < 150) begin
        pick = $urandom_range(99);
        s = rand_stride();
        if (pick < 8) begin
          frm = (pick < 6) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
          send_beat(mk_req(OP_FRAME, 3'($urandom_range(7)), frm, 20'($urandom),
                           9'($urandom)));
        end else if (pick < 65) begin
          c = rand_count(s);
          send_beat(mk_req(OP_LOCK, 3'($urandom), 4'($urandom), c, s));
          if (last_grant.status == ST_OK && $urandom_range(99) < 75) begin
            cu = $urandom_range(1) ? c : 20'($urandom_range(1, c));
            send_beat(mk_req(OP_UNLOCK, 3'($urandom), 4'($urandom), cu, s));
            sent_n++;
          end
        end else if (pick < 85) begin
          send_beat(mk_req(OP_UNLOCK, 3'($urandom), 4'($urandom), rand_count(s), s));
        end else if (pick < 90) begin
          send_beat(mk_req(OP_UNUSED, 3'($urandom), 4'($urandom), 20'($urandom),
                           9'($urandom)));
        end else begin
          send_beat(mk_req(OP_LOCK, 3'($urandom), 4'($urandom),
                           $urandom_range(3) == 0 ? 20'd0 : 20'($urandom),
                           $urandom_range(3) == 0 ? 9'd0 : 9'($urandom)));
        end
        sent_n++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    op_i = OP_FRAME;
    frame_slot_i = '0;
    frames_in_flight_i = '0;
    vertex_count_i = '0;
    stride_i = '0;
    buf_size = BUF_RESET;
    region_size = BUF_RESET;
    position = '0;
    region_base = '0;
    discard_total = '0;
    peak_bytes_n = '0;
    frame_wraps_n = '0;
    frame_calls_n = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_lock_corners();
    test_frame_resets();
    test_unlock_wraparound();
    test_buffer_extremes();
    test_random_traffic();
    settle();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("frame_ring_vertex_allocator_core verification clean");
    end else begin
      $display("frame_ring_vertex_allocator_core verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("frame_ring_vertex_allocator_core verification failed");
    $finish;
  end

endmodule

// ----- frame_ring_vertex_allocator_core.f -----
sv/frvac_pkg.sv
sv/frvac_div.sv
sv/frame_ring_vertex_allocator_core.sv
bench/testbench.sv
